[rtl/nearest_neighbor_tour_core_defines.svh]
// ----------------------------------------------------------------------------
// nearest_neighbor_tour_core_defines
// Assertion macros shared by the tour core checker.
// ----------------------------------------------------------------------------
`ifndef NEAREST_NEIGHBOR_TOUR_CORE_DEFINES_SVH
`define NEAREST_NEIGHBOR_TOUR_CORE_DEFINES_SVH

// same-cycle implication
`define NNT_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("nnt same-cycle check failed");

// next-cycle implication
`define NNT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("nnt next-cycle check failed");

`endif

[rtl/nnt_pkg.sv]
// ----------------------------------------------------------------------------
// nnt_pkg
// Shared types and constants of the nearest-neighbor tour core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package nnt_pkg;

   localparam int COST_W = 16;
   localparam int TIME_W = 20;
   localparam int NODE_W = 4;
   localparam logic [TIME_W-1:0] TIME_MAX = 20'hFFFFF;

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_HEAD,
      ST_STEP,
      ST_READ,
      ST_CMP,
      ST_HOP,
      ST_RET_READ,
      ST_RET_ADD,
      ST_TAIL
   } nnt_state_type;

   // sequencer -> search unit
   typedef struct packed {
      logic start;     // new tour: visited = {0}, current = 0, sum = 0
      logic step_init; // clear best candidate
      logic cand;      // compare read word against best
      logic commit;    // take best: add cost, mark, move
      logic ret_add;   // add read word (edge back to node 0)
   } nnt_srch_ctl_type;

endpackage

`default_nettype wire

[rtl/nnt_cost_mem.sv]
// ----------------------------------------------------------------------------
// nnt_cost_mem
// Cost matrix store: one write port, one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module nnt_cost_mem #(
   parameter int AW = 8
) (
   input  wire logic                      clock,
   input  wire logic                      wr_en,
   input  wire logic [AW-1:0]             wr_addr,
   input  wire logic [nnt_pkg::COST_W-1:0] wr_data,
   input  wire logic                      rd_en,
   input  wire logic [AW-1:0]             rd_addr,
   output      logic [nnt_pkg::COST_W-1:0] rd_data
);

   logic [nnt_pkg::COST_W-1:0] mem [2**AW];
   logic [nnt_pkg::COST_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[rtl/nnt_search.sv]
// ----------------------------------------------------------------------------
// nnt_search
// Shared compare / accumulate unit: tracks visited nodes, current node,
// best candidate of the running scan and the saturating tour time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module nnt_search #(
   parameter int NW = 4
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire nnt_pkg::nnt_srch_ctl_type  ctl,
   input  wire logic [NW-1:0]              cand_idx,
   input  wire logic [nnt_pkg::COST_W-1:0] rd_data,
   output      logic [NW-1:0]              cur_node,
   output      logic [NW-1:0]              best_node,
   output      logic [nnt_pkg::TIME_W-1:0] time_sum
);

   localparam int NODES = 2**NW;

   logic [NODES-1:0]              visited_ff, visited_in;
   logic [NW-1:0]                 cur_ff, cur_in;
   logic [NW-1:0]                 best_ff, best_in;
   logic [nnt_pkg::COST_W-1:0]    best_cost_ff, best_cost_in;
   logic                          found_ff, found_in;
   logic [nnt_pkg::TIME_W-1:0]    sum_ff, sum_in;
   logic [nnt_pkg::COST_W-1:0]    addend;
   logic [nnt_pkg::TIME_W:0]      sum_wide;
   logic                          take;

   // one adder for both the hop cost and the closing edge
   assign addend   = ctl.commit ? best_cost_ff : rd_data;
   assign sum_wide = {1'b0, sum_ff} + (nnt_pkg::TIME_W+1)'(addend);
   assign take     = !visited_ff[cand_idx] && (!found_ff || (rd_data < best_cost_ff));

   always_comb begin
      visited_in   = visited_ff;
      cur_in       = cur_ff;
      best_in      = best_ff;
      best_cost_in = best_cost_ff;
      found_in     = found_ff;
      sum_in       = sum_ff;
      if (ctl.start) begin
         visited_in = NODES'(1);
         cur_in     = '0;
         sum_in     = '0;
      end
      if (ctl.step_init) begin
         found_in = 1'b0;
      end
      if (ctl.cand && take) begin
         found_in     = 1'b1;
         best_in      = cand_idx;
         best_cost_in = rd_data;
      end
      if (ctl.commit) begin
         visited_in[best_ff] = 1'b1;
         cur_in              = best_ff;
      end
      if (ctl.commit || ctl.ret_add) begin
         sum_in = sum_wide[nnt_pkg::TIME_W] ? nnt_pkg::TIME_MAX
                                            : sum_wide[nnt_pkg::TIME_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         visited_ff <= NODES'(1);
         cur_ff     <= '0;
         sum_ff     <= '0;
         found_ff   <= 1'b0;
      end else begin
         visited_ff <= visited_in;
         cur_ff     <= cur_in;
         sum_ff     <= sum_in;
         found_ff   <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      best_ff      <= best_in;
      best_cost_ff <= best_cost_in;
   end

   assign cur_node  = cur_ff;
   assign best_node = best_ff;
   assign time_sum  = sum_ff;

endmodule

`default_nettype wire

[rtl/nearest_neighbor_tour_core.sv]
// ----------------------------------------------------------------------------
// nearest_neighbor_tour_core
// Greedy nearest-neighbor tour over a loaded square cost matrix.
// ----------------------------------------------------------------------------
//
//  channel | direction | words                     | handshake
//  --------+-----------+---------------------------+--------------------
//  req_    | in        | one cost word, row-major  | req_valid/req_ready
//  rsp_    | out       | route node, time, last    | rsp_valid/rsp_ready
//  csr_    | in        | node_count write          | csr_valid/csr_ready
//
//  Loading: one cost word per cycle while req_ready is high, P*P words with P = node_count+1.
//  Tour: after the last word the sequencer runs one compare unit over a
//    registered memory read, a read state and a compare state per candidate;
//    the rsp_ side can stall the tour while a word is already pending.
//  req_ready is low from the final matrix word until the closing node is
//    handed to the output register. No clearing pass after reset.
//  Reset (synchronous) clears node_count, load position and rsp_valid.
//  A csr write restarts loading at the first matrix word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module nearest_neighbor_tour_core #(
   parameter int MAX_NODES = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // matrix words
   input  wire logic        req_valid,
   output      logic        req_ready,
   input  wire logic [15:0] req_cost,
   // route words
   output      logic        rsp_valid,
   input  wire logic        rsp_ready,
   output      logic [3:0]  rsp_route_node,
   output      logic [19:0] rsp_total_time,
   output      logic        rsp_last,
   // node_count register
   input  wire logic        csr_valid,
   output      logic        csr_ready,
   input  wire logic [3:0]  csr_node_count
);

   // node_count is 4 bits, so a tour never has more than 16 nodes
   localparam int NODE_LIM = (MAX_NODES < 16) ? MAX_NODES : 16;
   localparam int NW       = $clog2(NODE_LIM);
   localparam int AW       = 2 * NW;
   localparam logic [3:0] LIM_M1 = 4'(NODE_LIM - 1);

   nnt_pkg::nnt_state_type state_ff, state_in;
   nnt_pkg::nnt_srch_ctl_type srch_ctl;

   logic [3:0]    node_count_ff;
   logic [NW-1:0] last_idx;          // P-1
   logic [NW-1:0] lrow_ff, lrow_in;  // load position
   logic [NW-1:0] lcol_ff, lcol_in;
   logic [NW-1:0] scan_ff, scan_in;  // candidate column
   logic [NW-1:0] step_ff, step_in;  // hop number
   logic          req_acc, csr_acc, out_free, out_load;
   logic [NW-1:0] out_node;
   logic          out_last;

   logic                       rd_en;
   logic [AW-1:0]              rd_addr;
   logic [nnt_pkg::COST_W-1:0] rd_data;
   logic [NW-1:0]              cur_node, best_node;
   logic [nnt_pkg::TIME_W-1:0] time_sum;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic [3:0]                 rsp_node_ff;
   logic [nnt_pkg::TIME_W-1:0] rsp_time_ff;
   logic                       rsp_last_ff;

   assign last_idx  = (node_count_ff > LIM_M1) ? LIM_M1[NW-1:0] : node_count_ff[NW-1:0];
   assign csr_ready = (state_ff == nnt_pkg::ST_LOAD);
   assign req_ready = (state_ff == nnt_pkg::ST_LOAD) && !csr_valid;
   assign req_acc   = req_valid && req_ready;
   assign csr_acc   = csr_valid && csr_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // ---------------- next state ----------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         nnt_pkg::ST_LOAD: begin
            if (req_acc && (lrow_ff == last_idx) && (lcol_ff == last_idx)) begin
               state_in = nnt_pkg::ST_HEAD;
            end
         end
         nnt_pkg::ST_HEAD: begin
            if (out_free) begin
               state_in = (last_idx == '0) ? nnt_pkg::ST_RET_READ : nnt_pkg::ST_STEP;
            end
         end
         nnt_pkg::ST_STEP:     state_in = nnt_pkg::ST_READ;
         nnt_pkg::ST_READ:     state_in = nnt_pkg::ST_CMP;
         nnt_pkg::ST_CMP: begin
            state_in = (scan_ff == last_idx) ? nnt_pkg::ST_HOP : nnt_pkg::ST_READ;
         end
         nnt_pkg::ST_HOP: begin
            if (out_free) begin
               state_in = (step_ff == last_idx) ? nnt_pkg::ST_RET_READ : nnt_pkg::ST_STEP;
            end
         end
         nnt_pkg::ST_RET_READ: state_in = nnt_pkg::ST_RET_ADD;
         nnt_pkg::ST_RET_ADD:  state_in = nnt_pkg::ST_TAIL;
         nnt_pkg::ST_TAIL: begin
            if (out_free) begin
               state_in = nnt_pkg::ST_LOAD;
            end
         end
         default:              state_in = nnt_pkg::ST_LOAD;
      endcase
   end

   // ---------------- outputs / counters ----------------
   always_comb begin
      srch_ctl = '0;
      rd_en    = 1'b0;
      rd_addr  = {cur_node, scan_ff};
      out_load = 1'b0;
      out_node = '0;
      out_last = 1'b0;
      lrow_in  = lrow_ff;
      lcol_in  = lcol_ff;
      scan_in  = scan_ff;
      step_in  = step_ff;
      unique case (state_ff)
         nnt_pkg::ST_LOAD: begin
            if (csr_acc) begin
               lrow_in = '0;
               lcol_in = '0;
            end else if (req_acc) begin
               if (lcol_ff == last_idx) begin
                  lcol_in = '0;
                  lrow_in = (lrow_ff == last_idx) ? '0 : lrow_ff + 1'b1;
               end else begin
                  lcol_in = lcol_ff + 1'b1;
               end
            end
         end
         nnt_pkg::ST_HEAD: begin
            if (out_free) begin
               out_load       = 1'b1;
               srch_ctl.start = 1'b1;
               step_in        = NW'(1);
            end
         end
         nnt_pkg::ST_STEP: begin
            srch_ctl.step_init = 1'b1;
            scan_in            = '0;
         end
         nnt_pkg::ST_READ: begin
            rd_en = 1'b1;
         end
         nnt_pkg::ST_CMP: begin
            srch_ctl.cand = 1'b1;
            scan_in       = scan_ff + 1'b1;
         end
         nnt_pkg::ST_HOP: begin
            if (out_free) begin
               out_load        = 1'b1;
               out_node        = best_node;
               srch_ctl.commit = 1'b1;
               step_in         = step_ff + 1'b1;
            end
         end
         nnt_pkg::ST_RET_READ: begin
            rd_en   = 1'b1;
            rd_addr = {cur_node, {NW{1'b0}}};
         end
         nnt_pkg::ST_RET_ADD: begin
            srch_ctl.ret_add = 1'b1;
         end
         nnt_pkg::ST_TAIL: begin
            if (out_free) begin
               out_load = 1'b1;
               out_last = 1'b1;
            end
         end
         default: begin
            srch_ctl = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= nnt_pkg::ST_LOAD;
         node_count_ff <= '0;
         lrow_ff       <= '0;
         lcol_ff       <= '0;
      end else begin
         state_ff <= state_in;
         lrow_ff  <= lrow_in;
         lcol_ff  <= lcol_in;
         if (csr_acc) begin
            node_count_ff <= csr_node_count;
         end
      end
   end

   always_ff @(posedge clock) begin
      scan_ff <= scan_in;
      step_ff <= step_in;
   end

   // ---------------- output register ----------------
   assign rsp_valid_in = out_load || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_node_ff <= 4'(out_node);
         rsp_time_ff <= out_last ? time_sum : '0;
         rsp_last_ff <= out_last;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_route_node = rsp_node_ff;
   assign rsp_total_time = rsp_time_ff;
   assign rsp_last       = rsp_last_ff;

   // ---------------- datapath ----------------
   nnt_cost_mem #(
      .AW(AW)
   ) u_cost_mem (
      .clock   (clock),
      .wr_en   (req_acc),
      .wr_addr ({lrow_ff, lcol_ff}),
      .wr_data (req_cost),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   nnt_search #(
      .NW(NW)
   ) u_search (
      .clock     (clock),
      .reset     (reset),
      .ctl       (srch_ctl),
      .cand_idx  (scan_ff),
      .rd_data   (rd_data),
      .cur_node  (cur_node),
      .best_node (best_node),
      .time_sum  (time_sum)
   );

endmodule

`default_nettype wire

[rtl/nnt_checker.sv]
// ----------------------------------------------------------------------------
// nnt_checker
// Port-level checks of the tour core, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "nearest_neighbor_tour_core_defines.svh"

module nnt_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [3:0]  rsp_route_node,
   input wire logic [19:0] rsp_total_time,
   input wire logic        rsp_last
);

   // a stalled route word holds
   `NNT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
                    rsp_valid && $stable(rsp_route_node) && $stable(rsp_last))

   // no matrix word taken while a tour is still being handed out
   `NNT_ASSERT_NOW(a_busy_tour, clock, reset, rsp_valid && !rsp_last, !req_ready)

   // time only rides on the closing word
   `NNT_ASSERT_NOW(a_time_tail, clock, reset, rsp_valid && !rsp_last, rsp_total_time == 20'd0)

   // the tour closes at node 0
   `NNT_ASSERT_NOW(a_tail_home, clock, reset, rsp_valid && rsp_last, rsp_route_node == 4'd0)

endmodule

bind nearest_neighbor_tour_core nnt_checker u_nnt_checker (.*);

`default_nettype wire
